// ===== sv/quarter_rate_quadrature_detector_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quarter-rate quadrature detector
// Shared shorthands for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef QUARTER_RATE_QUADRATURE_DETECTOR_TOP_MACROS_SVH
`define QUARTER_RATE_QUADRATURE_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication
`define QRQD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qrqd check failed");

// Next-cycle implication
`define QRQD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qrqd check failed");

`endif

// ===== sv/qrqd_pkg.sv =====
// ----------------------------------------------------------------------------
// qrqd_pkg
// Widths, constants and shared types of the quadrature detector.
// ----------------------------------------------------------------------------
package qrqd_pkg;

    localparam int AXES       = 3;
    localparam int TIME_W     = 32;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 26;
    localparam int MAG_W      = 25;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int AMP_W      = 25;
    localparam int REM_W      = AMP_W + 2;
    localparam int ITER_W     = $clog2(AMP_W);
    localparam int PERIODS_W  = 8;
    localparam int COUNT_W    = PERIODS_W + 1;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int AXIS_W     = $clog2(AXES);
    localparam int S_DATA_W   = 80;
    localparam int M_DATA_W   = 112;

    localparam logic [PERIODS_W-1:0] PERIODS_RESET = PERIODS_W'(10);

    // One finished block handed from the front to the back
    typedef struct packed {
        logic [TIME_W-1:0]            block_time;
        logic [AXES-1:0][SUM_W-1:0]   isum;
        logic [AXES-1:0][SUM_W-1:0]   qsum;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== sv/qrqd_front.sv =====
// ----------------------------------------------------------------------------
// qrqd_front
// Accepts samples, demodulates them into per-axis I/Q sums and hands a
// finished block to the job queue.
// ----------------------------------------------------------------------------
module qrqd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [qrqd_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [qrqd_pkg::PERIODS_W-1:0] i_cfg_data,
    input  qrqd_pkg::t_qstat              i_qstat,
    output qrqd_pkg::t_push               o_push
);
    import qrqd_pkg::*;

    typedef enum logic [1:0] {PH_IADD, PH_QADD, PH_ISUB, PH_QSUB} t_phase;

    t_phase                  r_phase;
    logic [PERIODS_W-1:0]    r_period;
    logic [PERIODS_W-1:0]    r_periods;
    logic [TIME_W-1:0]       r_held;
    logic signed [SUM_W-1:0] r_isum [AXES];
    logic signed [SUM_W-1:0] r_qsum [AXES];
    logic signed [SUM_W-1:0] n_isum [AXES];
    logic signed [SUM_W-1:0] n_qsum [AXES];
    logic signed [SUM_W-1:0] w_smp  [AXES];

    logic [TIME_W-1:0]  w_time;
    logic [COUNT_W-1:0] w_done;
    logic [COUNT_W-1:0] w_target;
    logic               w_accept;
    logic               w_last;

    assign s_axis_tready = !i_qstat.full;
    assign o_cfg_ready   = 1'b1;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_time        = s_axis_tdata[TIME_W-1:0];

    // unpack and sign-extend the three axes
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            w_smp[a] = SUM_W'($signed(s_axis_tdata[TIME_W + a*SAMPLE_W +: SAMPLE_W]));
        end
    end

    // demodulation: +I, +Q, -I, -Q
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_isum[a] = r_isum[a];
            n_qsum[a] = r_qsum[a];
            unique case (r_phase)
                PH_IADD: n_isum[a] = r_isum[a] + w_smp[a];
                PH_QADD: n_qsum[a] = r_qsum[a] + w_smp[a];
                PH_ISUB: n_isum[a] = r_isum[a] - w_smp[a];
                PH_QSUB: n_qsum[a] = r_qsum[a] - w_smp[a];
                default: n_isum[a] = r_isum[a];
            endcase
        end
    end

    // end of block: setting of zero means 256 periods
    assign w_done   = {1'b0, r_period} + COUNT_W'(1);
    assign w_target = (r_periods == '0) ? COUNT_W'(1 << PERIODS_W) : {1'b0, r_periods};
    assign w_last   = (r_phase == PH_QSUB) && (w_done >= w_target);

    // job handed to the queue
    always_comb begin
        o_push.valid           = w_accept && w_last;
        o_push.job.block_time  = r_held;
        for (int a = 0; a < AXES; a++) begin
            o_push.job.isum[a] = n_isum[a];
            o_push.job.qsum[a] = n_qsum[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IADD;
            r_period  <= '0;
            r_periods <= PERIODS_RESET;
            r_held    <= '0;
            for (int a = 0; a < AXES; a++) begin
                r_isum[a] <= '0;
                r_qsum[a] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_periods <= i_cfg_data;
            end
            if (w_accept) begin
                r_phase <= t_phase'(r_phase + 2'd1);
                if (r_phase == PH_IADD) begin
                    r_held <= w_time;
                end
                for (int a = 0; a < AXES; a++) begin
                    r_isum[a] <= w_last ? '0 : n_isum[a];
                    r_qsum[a] <= w_last ? '0 : n_qsum[a];
                end
                if (w_last) begin
                    r_period <= '0;
                end else if (r_phase == PH_QSUB) begin
                    r_period <= w_done[PERIODS_W-1:0];
                end
            end
        end
    end

endmodule

// ===== sv/qrqd_queue.sv =====
// ----------------------------------------------------------------------------
// qrqd_queue
// Small job queue between the front and the back.
// ----------------------------------------------------------------------------
module qrqd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  qrqd_pkg::t_push  i_push,
    input  logic             i_pop,
    output qrqd_pkg::t_job   o_head,
    output qrqd_pkg::t_qstat o_qstat
);
    import qrqd_pkg::*;
    `include "quarter_rate_quadrature_detector_top_macros.svh"

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_head        = r_mem[r_rd];
    assign o_qstat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push.valid && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push.valid) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    `QRQD_ASSERT_IMPLY(a_no_push_full, i_clk, i_rst_n, i_push.valid, !o_qstat.full)
    `QRQD_ASSERT_IMPLY(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_qstat.empty)
    `QRQD_ASSERT_IMPLY(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= QCNT_W'(QDEPTH))

endmodule

// ===== sv/qrqd_back.sv =====
// ----------------------------------------------------------------------------
// qrqd_back
// Per axis: squares I and Q on one shared multiplier, then takes the floor
// square root one result bit per cycle; holds the result in the output stage.
// ----------------------------------------------------------------------------
module qrqd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qrqd_pkg::t_job                i_head,
    input  qrqd_pkg::t_qstat              i_qstat,
    output logic                          o_pop,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [qrqd_pkg::M_DATA_W-1:0] m_axis_tdata
);
    import qrqd_pkg::*;
    `include "quarter_rate_quadrature_detector_top_macros.svh"

    typedef enum logic [2:0] {S_IDLE, S_SQI, S_SQQ, S_ADD, S_ROOT, S_OUT} t_state;

    t_state              r_state;
    logic [AXIS_W-1:0]   r_axis;
    logic [ITER_W-1:0]   r_iter;
    logic [SQ_W-1:0]     r_sq_i;
    logic [SQ_W-1:0]     r_sq_q;
    logic [SQ_W-1:0]     r_rad;
    logic [REM_W-1:0]    r_rem;
    logic [AMP_W-1:0]    r_root;
    logic [AMP_W-1:0]    r_amp [AXES];
    logic                r_m_valid;
    logic [TIME_W-1:0]   r_m_time;
    logic [AMP_W-1:0]    r_m_amp [AXES];

    logic [SUM_W-1:0]    w_sum;
    logic [SUM_W-1:0]    w_abs;
    logic [MAG_W-1:0]    w_mag;
    logic [REM_W+1:0]    w_shift;
    logic [REM_W+1:0]    w_trial;
    logic                w_take;
    logic [REM_W-1:0]    n_rem;
    logic [AMP_W-1:0]    n_root;
    logic                w_slot;

    // multiplier operand: |I| or |Q| of the current axis
    assign w_sum = (r_state == S_SQI) ? i_head.isum[r_axis] : i_head.qsum[r_axis];
    assign w_abs = w_sum[SUM_W-1] ? (~w_sum + SUM_W'(1)) : w_sum;
    assign w_mag = w_abs[MAG_W-1:0];

    // one restoring square-root step
    assign w_shift = {r_rem, r_rad[SQ_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_take  = (w_shift >= w_trial);
    assign n_rem   = w_take ? REM_W'(w_shift - w_trial) : w_shift[REM_W-1:0];
    assign n_root  = {r_root[AMP_W-2:0], w_take};

    assign w_slot = !r_m_valid || m_axis_tready;
    assign o_pop  = (r_state == S_OUT) && w_slot;

    // output beat: block_time, amplitude_x, amplitude_y, amplitude_z
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {(M_DATA_W - TIME_W - AXES*AMP_W)'(0),
                            r_m_amp[2], r_m_amp[1], r_m_amp[0], r_m_time};

    // sequencer and output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_axis    <= '0;
            r_iter    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // beat taken and no new one loaded behind it
            if (r_m_valid && m_axis_tready && !o_pop) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_qstat.empty) begin
                        r_axis  <= '0;
                        r_state <= S_SQI;
                    end
                end
                S_SQI: begin
                    r_sq_i  <= w_mag * w_mag;
                    r_state <= S_SQQ;
                end
                S_SQQ: begin
                    r_sq_q  <= w_mag * w_mag;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_rad   <= r_sq_i + r_sq_q;
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_iter  <= ITER_W'(AMP_W - 1);
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_rad  <= {r_rad[SQ_W-3:0], 2'b00};
                    r_rem  <= n_rem;
                    r_root <= n_root;
                    r_iter <= r_iter - ITER_W'(1);
                    if (r_iter == '0) begin
                        r_amp[r_axis] <= n_root;
                        if (r_axis == AXIS_W'(AXES - 1)) begin
                            r_state <= S_OUT;
                        end else begin
                            r_axis  <= r_axis + AXIS_W'(1);
                            r_state <= S_SQI;
                        end
                    end
                end
                S_OUT: begin
                    if (w_slot) begin
                        r_m_valid <= 1'b1;
                        r_m_time  <= i_head.block_time;
                        for (int a = 0; a < AXES; a++) begin
                            r_m_amp[a] <= r_amp[a];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `QRQD_ASSERT_IMPLY(a_job_held, i_clk, i_rst_n, r_state != S_IDLE, !i_qstat.empty)
    `QRQD_ASSERT_NEXT(a_out_loaded, i_clk, i_rst_n, o_pop, r_m_valid)
    `QRQD_ASSERT_IMPLY(a_axis_range, i_clk, i_rst_n, r_state != S_IDLE, r_axis < AXIS_W'(AXES))

endmodule

// ===== sv/quarter_rate_quadrature_detector_top.sv =====
// One sample beat is taken per cycle while the two-entry job queue has room.
// After the block's closing phase-3 beat, the result is built per axis from
// the squares of I and Q on the shared multiplier, one add and 25 square-root steps.
// The root unit handles one block at a time and so sets the result rate;
// sample beats stall only when two finished blocks are still waiting.
// Synchronous active-low reset clears phase, counters, sums, queue and output.
// ----------------------------------------------------------------------------
// quarter_rate_quadrature_detector_top
// Three-axis fs/4 quadrature demodulator with per-axis amplitude output.
// ----------------------------------------------------------------------------
module quarter_rate_quadrature_detector_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample_time[31:0], axis_x[47:32], axis_y[63:48], axis_z[79:64]
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [qrqd_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // block_time[31:0], amplitude_x[56:32], amplitude_y[81:57],
    // amplitude_z[106:82], zero fill above
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [qrqd_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // periods_per_block
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [qrqd_pkg::PERIODS_W-1:0] i_cfg_data
);
    import qrqd_pkg::*;

    t_push  w_push;
    t_job   w_head;
    t_qstat w_qstat;
    logic   w_pop;

    qrqd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_qstat       (w_qstat),
        .o_push        (w_push)
    );

    qrqd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    qrqd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_qstat       (w_qstat),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
